// ===== sv/vsf_pkg.sv =====
// vsf_pkg: shared types, widths, codes and default sizes of the scanline fetcher
// no dependencies; compile first
package vsf_pkg;

    // default frame store geometry
    localparam int ROWS_DEF      = 80;
    localparam int ROW_BYTES_DEF = 24;

    // field widths
    localparam int CMD_W      = 2;
    localparam int ADDR_IN_W  = 11;
    localparam int DATA_W     = 8;
    localparam int ROW_W      = 7;
    localparam int COLOR_W    = 2;
    localparam int SKIP_W     = 8;
    localparam int LPR_W      = 4;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // input commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LINES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_ROW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MASK = 2'd2;

    // config reset values
    localparam logic [SKIP_W-1:0]  SKIP_RST  = 8'd35;
    localparam logic [LPR_W-1:0]   LPR_RST   = 4'd6;
    localparam logic [COLOR_W-1:0] COLOR_RST = 2'd0;

    // repeat count limits
    localparam logic [LPR_W-1:0] LPR_MIN = 4'd1;
    localparam logic [LPR_W-1:0] LPR_MAX = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic clr_we;
        logic in_ready;
        logic issue;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic show;
        logic clr_last;
        logic can_issue;
        logic byte_last;
    } t_dp_status;

    // one output beat
    typedef struct packed {
        logic [DATA_W-1:0]  pixels;
        logic [COLOR_W-1:0] extra_color;
        logic [ROW_W-1:0]   row;
        logic               last;
    } t_out_beat;

endpackage

// ===== sv/vsf_ifs.sv =====
// vsf_ifs: valid/ready channel interfaces for input items, output beats and config writes
// depends on vsf_pkg
interface vsf_in_if;
    logic                          valid;
    logic                          ready;
    logic [vsf_pkg::CMD_W-1:0]     cmd;
    logic [vsf_pkg::ADDR_IN_W-1:0] addr;
    logic [vsf_pkg::DATA_W-1:0]    data;

    modport source (output valid, output cmd, output addr, output data, input ready);
    modport sink   (input valid, input cmd, input addr, input data, output ready);
endinterface

interface vsf_out_if;
    logic                        valid;
    logic                        ready;
    logic [vsf_pkg::DATA_W-1:0]  pixels;
    logic [vsf_pkg::COLOR_W-1:0] extra_color;
    logic [vsf_pkg::ROW_W-1:0]   row;
    logic                        last;

    modport source (output valid, output pixels, output extra_color, output row,
                    output last, input ready);
    modport sink   (input valid, input pixels, input extra_color, input row,
                    input last, output ready);
endinterface

interface vsf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vsf_pkg::CFG_IDX_W-1:0]  index;
    logic [vsf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/vga_scanline_fetcher_top.sv =====
// vga_scanline_fetcher_top: 1-bit-per-pixel frame store with line-repeat scanline fetch
// a write, frame start, blank or off-screen tick leaves the intake ready; a shown line tick
// reads ROW_BYTES bytes from the single read port, one per cycle while the output queue has room;
// the first beat passes the emit state, the read register and the output queue; the next item
// is taken once the last byte read issues; output stalls hold the reads back; reset: synchronous
// active low, counters clear, config defaults, then a clearing pass over all ROWS*ROW_BYTES bytes
module vga_scanline_fetcher_top #(
    parameter int ROWS      = vsf_pkg::ROWS_DEF,
    parameter int ROW_BYTES = vsf_pkg::ROW_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vsf_in_if.sink           i_in_ch,
    vsf_out_if.source        o_out_ch,
    vsf_cfg_if.sink          i_cfg_ch
);
    import vsf_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;
    t_out_beat  out_beat;

    // controller
    vsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_cmd   (i_in_ch.cmd),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd)
    );

    // datapath
    vsf_datapath #(
        .ROWS      (ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl_cmd),
        .o_status    (dp_status),
        .i_in_valid  (i_in_ch.valid),
        .i_in_cmd    (i_in_ch.cmd),
        .i_in_addr   (i_in_ch.addr),
        .i_in_data   (i_in_ch.data),
        .i_cfg_valid (i_cfg_ch.valid),
        .i_cfg_index (i_cfg_ch.index),
        .i_cfg_data  (i_cfg_ch.data),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_out_beat  (out_beat)
    );

    // channel hookup
    assign i_in_ch.ready        = ctl_cmd.in_ready;
    assign i_cfg_ch.ready       = 1'b1;
    assign o_out_ch.pixels      = out_beat.pixels;
    assign o_out_ch.extra_color = out_beat.extra_color;
    assign o_out_ch.row         = out_beat.row;
    assign o_out_ch.last        = out_beat.last;

endmodule

// ===== sv/vsf_ctrl.sv =====
// vsf_ctrl: controller fsm; clearing pass, item intake and line read sequencing
// depends on vsf_pkg
module vsf_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [vsf_pkg::CMD_W-1:0] i_in_cmd,
    input  vsf_pkg::t_dp_status       i_status,
    output vsf_pkg::t_ctl_cmd         o_cmd
);
    import vsf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    // command outputs
    always_comb begin
        o_cmd.clr_we   = (r_state == ST_CLEAR);
        o_cmd.in_ready = (r_state == ST_IDLE);
        o_cmd.issue    = (r_state == ST_EMIT) && i_status.can_issue;
    end

    assign in_fire = i_in_valid && (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire && (i_in_cmd == CMD_TICK) && i_status.show) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.can_issue && i_status.byte_last) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

endmodule

// ===== sv/vsf_datapath.sv =====
// vsf_datapath: config registers, line counters, frame store memory and output queue
// depends on vsf_pkg
module vsf_datapath #(
    parameter int ROWS      = vsf_pkg::ROWS_DEF,
    parameter int ROW_BYTES = vsf_pkg::ROW_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vsf_pkg::t_ctl_cmd              i_ctl,
    output vsf_pkg::t_dp_status            o_status,
    input  logic                           i_in_valid,
    input  logic [vsf_pkg::CMD_W-1:0]      i_in_cmd,
    input  logic [vsf_pkg::ADDR_IN_W-1:0]  i_in_addr,
    input  logic [vsf_pkg::DATA_W-1:0]     i_in_data,
    input  logic                           i_cfg_valid,
    input  logic [vsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output vsf_pkg::t_out_beat             o_out_beat
);
    import vsf_pkg::*;

    localparam int STORE_SIZE = ROWS * ROW_BYTES;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int BASE_W     = $clog2(STORE_SIZE + 1);
    localparam int BYTE_W     = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int CMP_W      = ((ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W) + 1;

    localparam logic [CMP_W-1:0]  STORE_LIM = CMP_W'(STORE_SIZE);
    localparam logic [ADDR_W-1:0] CLR_END   = ADDR_W'(STORE_SIZE - 1);
    localparam logic [BYTE_W-1:0] BYTE_END  = BYTE_W'(ROW_BYTES - 1);
    localparam logic [ROW_W-1:0]  ROW_LIM   = ROW_W'(ROWS);
    localparam logic [BASE_W-1:0] BASE_STEP = BASE_W'(ROW_BYTES);

    // config registers
    logic [SKIP_W-1:0]  r_skip_lines;
    logic [LPR_W-1:0]   r_lines_row;
    logic [COLOR_W-1:0] r_color_mask;

    // line counters
    logic [SKIP_W-1:0]  r_skip_left;
    logic [PHASE_W-1:0] r_phase;
    logic [ROW_W-1:0]   r_row_count;
    logic [BASE_W-1:0]  r_row_base;

    // line read state
    logic [ADDR_W-1:0]  r_rd_addr;
    logic [BYTE_W-1:0]  r_byte_cnt;
    logic [ROW_W-1:0]   r_line_row;
    logic [COLOR_W-1:0] r_line_color;
    logic [ADDR_W-1:0]  r_clr_addr;

    // memory read stage
    logic [DATA_W-1:0]  mem [STORE_SIZE];
    logic [DATA_W-1:0]  r_rd_data;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic [ROW_W-1:0]   r_rd_row;
    logic [COLOR_W-1:0] r_rd_color;

    // output queue
    t_out_beat          r_fifo [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_fifo_cnt;

    logic               in_fire;
    logic               tick;
    logic               show;
    logic               wr_ok;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [LPR_W-1:0]   rep_n;
    logic               phase_wrap;
    logic               pop;
    logic               push;
    t_out_beat          push_beat;

    assign in_fire = i_in_valid && i_ctl.in_ready;
    assign tick    = in_fire && (i_in_cmd == CMD_TICK);
    assign show    = (r_skip_left == '0) && (r_row_count < ROW_LIM);
    assign wr_ok   = CMP_W'(i_in_addr) < STORE_LIM;

    // repeat count clamped to 1..8
    always_comb begin
        if (r_lines_row < LPR_MIN)      rep_n = LPR_MIN;
        else if (r_lines_row > LPR_MAX) rep_n = LPR_MAX;
        else                            rep_n = r_lines_row;
    end
    assign phase_wrap = (LPR_W'(r_phase) + LPR_W'(1)) >= rep_n;

    // status to controller
    always_comb begin
        o_status.show      = show;
        o_status.clr_last  = (r_clr_addr == CLR_END);
        o_status.can_issue = ({1'b0, r_fifo_cnt} + {2'b00, r_rd_vld})
                             < (3'd2 + {2'b00, pop});
        o_status.byte_last = (r_byte_cnt == BYTE_END);
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_lines <= SKIP_RST;
            r_lines_row  <= LPR_RST;
            r_color_mask <= COLOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SKIP_LINES: r_skip_lines <= i_cfg_data[SKIP_W-1:0];
                CFG_LINES_ROW:  r_lines_row  <= i_cfg_data[LPR_W-1:0];
                CFG_COLOR_MASK: r_color_mask <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // frame and line counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_left <= '0;
            r_phase     <= '0;
            r_row_count <= '0;
            r_row_base  <= '0;
        end else if (in_fire && (i_in_cmd == CMD_FRAME)) begin
            r_skip_left <= r_skip_lines;
            r_phase     <= '0;
            r_row_count <= '0;
            r_row_base  <= '0;
        end else if (tick) begin
            if (r_skip_left != '0) begin
                r_skip_left <= r_skip_left - SKIP_W'(1);
            end else if (phase_wrap) begin
                r_phase <= '0;
                if (r_row_count < ROW_LIM) begin
                    r_row_count <= r_row_count + ROW_W'(1);
                    r_row_base  <= r_row_base + BASE_STEP;
                end
            end else begin
                r_phase <= r_phase + PHASE_W'(1);
            end
        end
    end

    // line read address and byte count
    always_ff @(posedge i_clk) begin
        if (tick && show) begin
            r_rd_addr    <= r_row_base[ADDR_W-1:0];
            r_byte_cnt   <= '0;
            r_line_row   <= r_row_count;
            r_line_color <= r_color_mask;
        end else if (i_ctl.issue) begin
            r_rd_addr  <= r_rd_addr + ADDR_W'(1);
            r_byte_cnt <= r_byte_cnt + BYTE_W'(1);
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_clr_addr <= '0;
        else if (i_ctl.clr_we) r_clr_addr <= r_clr_addr + ADDR_W'(1);
    end

    // memory write port: clearing pass or byte write
    always_comb begin
        mem_we    = i_ctl.clr_we || (in_fire && (i_in_cmd == CMD_WRITE) && wr_ok);
        mem_waddr = i_ctl.clr_we ? r_clr_addr : ADDR_W'(i_in_addr);
        mem_wdata = i_ctl.clr_we ? '0 : i_in_data;
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (i_ctl.issue) r_rd_data <= mem[r_rd_addr];
    end

    // read sideband
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_vld <= 1'b0;
        else          r_rd_vld <= i_ctl.issue;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_rd_last  <= (r_byte_cnt == BYTE_END);
            r_rd_row   <= r_line_row;
            r_rd_color <= r_line_color;
        end
    end

    // two-entry output queue
    assign pop  = o_out_valid && i_out_ready;
    assign push = r_rd_vld;

    always_comb begin
        push_beat.pixels      = r_rd_data;
        push_beat.extra_color = r_rd_color;
        push_beat.row         = r_rd_row;
        push_beat.last        = r_rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_fifo[r_wr_ptr] <= push_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= 1'b0;
            r_rd_ptr   <= 1'b0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + 2'd1;
                2'b01:   r_fifo_cnt <= r_fifo_cnt - 2'd1;
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
    end

    assign o_out_valid = (r_fifo_cnt != '0);
    assign o_out_beat  = r_fifo[r_rd_ptr];

endmodule
